// ===== hw/rtl/cdt_pkg.sv =====
package cdt_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ENTRY_W = 16;
  localparam int unsigned BAR_W   = 7;

  // Shift-add multiplier: 32-bit multiplicand, 16-bit multiplier.
  localparam int unsigned MUL_A_W = TIME_W;
  localparam int unsigned MUL_B_W = ENTRY_W;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // remaining * 100 needs 39 bits; the quotient stays below 2^BAR_W.
  localparam int unsigned PCT_NUM_W = TIME_W + BAR_W;

  localparam logic [MUL_B_W-1:0] SCALE_SECONDS = MUL_B_W'(1000);
  localparam logic [MUL_B_W-1:0] SCALE_MINUTES = MUL_B_W'(60000);
  localparam logic [MUL_B_W-1:0] PCT_FACTOR    = MUL_B_W'(100);
  localparam logic [BAR_W-1:0]   FULL_BAR      = BAR_W'(100);

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_PAUSED  = 2'd2,
    MODE_ALARM   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_TICK    = 3'd0,
    KIND_START   = 3'd1,
    KIND_STOP    = 3'd2,
    KIND_RESET   = 3'd3,
    KIND_CLEAR   = 3'd4,
    KIND_PREVIEW = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_EXEC,
    ST_CMP,
    ST_SCALE,
    ST_PCT,
    ST_DIV,
    ST_PUSH
  } state_e;

endpackage

// ===== hw/rtl/countdown_timer_with_pause.sv =====
// Millisecond countdown timer with pause and alarm. Each accepted event (tick,
// start, stop, reset, clear, entry preview) produces exactly one result that
// reports the timer state after the event. Stop, reset, clear, a resume from
// pause and ignored events pass the execute state and then the push state,
// which loads the output register. A start from idle or an entry preview also
// runs the bit-serial multiplier that forms entry * 1000 or entry * 60000 one
// entry bit per cycle and finishes once no entry bits are left. A tick that
// runs the countdown out goes from the compare straight to the push state.
// Any other tick while running passes these steps in order:
//   - the elapsed stamp difference,
//   - the compare against the remaining time,
//   - the shift-add unit for remaining * 100,
//   - the restoring divider, which yields the bar percentage one
//     quotient bit per cycle,
//   - the load of the output register.
// One event is worked on at a time, and the input stalls until its result has
// been loaded. A finished result sits in the output register while the next
// event is taken in. The block holds a new result back until the previous one
// has been transferred.
module countdown_timer_with_pause
  import cdt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic [TIME_W-1:0]  now_ms_i,
  input  logic [ENTRY_W-1:0] entry_value_i,
  input  logic               seconds_mode_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         timer_mode_o,
  output logic [TIME_W-1:0]  remaining_ms_o,
  output logic [TIME_W-1:0]  shown_ms_o,
  output logic [BAR_W-1:0]   bar_percent_o,
  output logic               alarm_active_o,
  output logic               clear_entry_o,
  output logic               entry_enabled_o
);

  state_e state_q, state_d;

  // timer state
  mode_e             mode_q, mode_d;
  logic [TIME_W-1:0] remaining_q, remaining_d;
  logic [TIME_W-1:0] start_q, start_d;
  logic [TIME_W-1:0] last_q, last_d;
  logic [TIME_W-1:0] shown_q, shown_d;
  logic [BAR_W-1:0]  bar_q, bar_d;
  logic              keypad_q, keypad_d;
  logic              clr_q, clr_d;
  logic [TIME_W-1:0] elapsed_q, elapsed_d;

  // captured event
  logic [2:0]         kind_q;
  logic [TIME_W-1:0]  now_q;
  logic [ENTRY_W-1:0] entry_q;
  logic               secs_q;

  // output register
  logic out_valid_q, out_valid_d;
  logic push;

  // serial arithmetic
  logic               mul_start;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_done;
  logic [MUL_P_W-1:0] mul_prod;
  logic               div_start;
  logic               div_done;
  logic [BAR_W-1:0]   div_quot;

  logic              in_xfer;
  logic [TIME_W:0]   diff;
  logic              expired;
  logic [MUL_B_W-1:0] scale;

  assign in_stall_o = (state_q != ST_WAIT);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // remaining - elapsed with borrow; zero or negative means the countdown ran out
  assign diff    = {1'b0, remaining_q} - {1'b0, elapsed_q};
  assign expired = diff[TIME_W] || (diff[TIME_W-1:0] == '0);
  assign scale   = secs_q ? SCALE_SECONDS : SCALE_MINUTES;

  cdt_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  cdt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mul_prod[PCT_NUM_W-1:0]),
    .den_i   (start_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    remaining_d = remaining_q;
    start_d     = start_q;
    last_d      = last_q;
    shown_d     = shown_q;
    bar_d       = bar_q;
    keypad_d    = keypad_q;
    clr_d       = clr_q;
    elapsed_d   = elapsed_q;
    mul_start   = 1'b0;
    mul_a       = MUL_A_W'(scale);
    mul_b       = entry_q;
    div_start   = 1'b0;
    push        = 1'b0;

    case (state_q)
      ST_WAIT: begin
        if (in_xfer) begin
          clr_d   = 1'b0;
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_d = ST_PUSH;
        case (kind_q)
          KIND_TICK: begin
            if (mode_q == MODE_RUNNING) begin
              elapsed_d = now_q - last_q;
              last_d    = now_q;
              state_d   = ST_CMP;
            end
          end
          KIND_START: begin
            if (mode_q == MODE_IDLE) begin
              // a zero entry leaves everything as it is
              if (entry_q != '0) begin
                mul_start = 1'b1;
                state_d   = ST_SCALE;
              end
            end else if (mode_q == MODE_PAUSED) begin
              mode_d   = MODE_RUNNING;
              last_d   = now_q;
              keypad_d = 1'b0;
            end
          end
          KIND_STOP: begin
            if (mode_q == MODE_RUNNING) begin
              mode_d = MODE_PAUSED;
            end else if (mode_q == MODE_ALARM) begin
              mode_d   = MODE_IDLE;
              keypad_d = 1'b1;
            end
          end
          KIND_RESET: begin
            mode_d      = MODE_IDLE;
            remaining_d = '0;
            shown_d     = '0;
            bar_d       = FULL_BAR;
            keypad_d    = 1'b1;
          end
          KIND_CLEAR: begin
            // silence the alarm; ask for an empty entry field once idle
            if (mode_q == MODE_ALARM) begin
              mode_d   = MODE_IDLE;
              keypad_d = 1'b1;
              clr_d    = 1'b1;
            end else if (mode_q == MODE_IDLE) begin
              clr_d = 1'b1;
            end
          end
          KIND_PREVIEW: begin
            if (mode_q == MODE_IDLE) begin
              mul_start = 1'b1;
              state_d   = ST_SCALE;
            end
          end
          default: begin
          end
        endcase
      end

      ST_CMP: begin
        if (expired) begin
          remaining_d = '0;
          shown_d     = '0;
          bar_d       = '0;
          mode_d      = MODE_ALARM;
          state_d     = ST_PUSH;
        end else begin
          remaining_d = diff[TIME_W-1:0];
          shown_d     = diff[TIME_W-1:0];
          if (start_q != '0) begin
            mul_start = 1'b1;
            mul_a     = diff[TIME_W-1:0];
            mul_b     = PCT_FACTOR;
            state_d   = ST_PCT;
          end else begin
            state_d = ST_PUSH;
          end
        end
      end

      ST_SCALE: begin
        if (mul_done) begin
          shown_d = mul_prod[TIME_W-1:0];
          if (kind_q == KIND_START) begin
            start_d     = mul_prod[TIME_W-1:0];
            remaining_d = mul_prod[TIME_W-1:0];
            bar_d       = FULL_BAR;
            mode_d      = MODE_RUNNING;
            last_d      = now_q;
            keypad_d    = 1'b0;
          end
          state_d = ST_PUSH;
        end
      end

      ST_PCT: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          bar_d   = div_quot;
          state_d = ST_PUSH;
        end
      end

      ST_PUSH: begin
        // hold the result until the previous one has been transferred
        if (!out_valid_q || !out_stall_i) begin
          push    = 1'b1;
          state_d = ST_WAIT;
        end
      end

      default: begin
        state_d = ST_WAIT;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (push) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WAIT;
      mode_q      <= MODE_IDLE;
      remaining_q <= '0;
      start_q     <= '0;
      last_q      <= '0;
      shown_q     <= '0;
      bar_q       <= FULL_BAR;
      keypad_q    <= 1'b1;
      clr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      remaining_q <= remaining_d;
      start_q     <= start_d;
      last_q      <= last_d;
      shown_q     <= shown_d;
      bar_q       <= bar_d;
      keypad_q    <= keypad_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // event capture and scratch
  always_ff @(posedge clk_i) begin
    elapsed_q <= elapsed_d;
    if (in_xfer) begin
      kind_q  <= kind_i;
      now_q   <= now_ms_i;
      entry_q <= entry_value_i;
      secs_q  <= seconds_mode_i;
    end
  end

  // result register: snapshot of the state after the event
  always_ff @(posedge clk_i) begin
    if (push) begin
      timer_mode_o    <= mode_q;
      remaining_ms_o  <= remaining_q;
      shown_ms_o      <= shown_q;
      bar_percent_o   <= bar_q;
      alarm_active_o  <= (mode_q == MODE_ALARM);
      clear_entry_o   <= clr_q;
      entry_enabled_o <= keypad_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/cdt_mul.sv =====
module cdt_mul
  import cdt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic               done_o,
  output logic [MUL_P_W-1:0] prod_o
);

  logic               busy_q;
  logic [MUL_P_W-1:0] acc_q;
  logic [MUL_P_W-1:0] a_q;
  logic [MUL_B_W-1:0] b_q;

  // finish as soon as no multiplier bits are left
  assign done_o = busy_q && (b_q == '0);
  assign prod_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  // one multiplier bit per cycle, LSB first
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= MUL_P_W'(a_i);
      b_q   <= b_i;
    end else if (busy_q && (b_q != '0)) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

endmodule

// ===== hw/rtl/cdt_div.sv =====
module cdt_div
  import cdt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [PCT_NUM_W-1:0] num_i,
  input  logic [TIME_W-1:0]    den_i,
  output logic                 done_o,
  output logic [BAR_W-1:0]     quot_o
);

  localparam int unsigned CNT_W = $clog2(BAR_W + 1);

  logic                busy_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [TIME_W-1:0]   rem_q;
  logic [TIME_W-1:0]   den_q;
  logic [BAR_W-1:0]    num_lo_q;
  logic [BAR_W-1:0]    quot_q;
  logic [TIME_W:0]     shifted;
  logic [TIME_W+1:0]   diff;
  logic                ge;

  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = quot_q;

  // restoring step: bring down one numerator bit, subtract if it fits
  assign shifted = {rem_q, num_lo_q[BAR_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};
  assign ge      = !diff[TIME_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(BAR_W);
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q    <= num_i[PCT_NUM_W-1:BAR_W];
      num_lo_q <= num_i[BAR_W-1:0];
      den_q    <= den_i;
      quot_q   <= '0;
    end else if (busy_q && (cnt_q != '0)) begin
      rem_q    <= ge ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
      num_lo_q <= num_lo_q << 1;
      quot_q   <= {quot_q[BAR_W-2:0], ge};
    end
  end

endmodule
